### src/tspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_pkg
// shared types and constants of the transport stream pid demultiplexer
// ----------------------------------------------------------------------------
package tspd_pkg;

   localparam int PID_W             = 13;
   localparam int PID_COUNT_DEFAULT = 8192;
   localparam int TS_PAYLOAD_SIZE   = 188;
   localparam int TS_HEADER_SIZE    = 4;

   localparam logic [7:0] SYNC_BYTE       = 8'h47;
   localparam logic [7:0] PKT_LEN_DEFAULT = 8'(TS_PAYLOAD_SIZE);

   localparam logic MODE_STREAM = 1'b0;
   localparam logic MODE_TABLE  = 1'b1;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_VIDEO = 2'd1;
   localparam logic [1:0] KIND_AUDIO = 2'd2;
   localparam logic [1:0] KIND_RSVD  = 2'd3;

   localparam logic [1:0] AFC_PAYLOAD_ONLY = 2'd1;
   localparam logic [1:0] AFC_ADAPT_AND_PL = 2'd3;

   typedef struct packed {
      logic [7:0]       payload_byte;
      logic [PID_W-1:0] stream_pid;
      logic [1:0]       stream_kind;
      logic             unit_start;
      logic             packet_end;
      logic             sync_error;
   } rsp_type;

   typedef struct packed {
      logic             rd_en;
      logic             set_start;
      logic             tbl_wr;
      logic [PID_W-1:0] pid;
      logic [1:0]       kind;
   } tbl_req_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] kind;
      logic       started;
   } tbl_stat_type;

endpackage

### src/tspd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module tspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tspd_pid_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_pid_table
// pid kind and started table in ram, clearing sweep after reset, and a cached
// copy of the current packet's entry kept coherent with table writes
// ----------------------------------------------------------------------------
module tspd_pid_table
   import tspd_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  tbl_req_type  req,
   output tbl_stat_type stat
);

   localparam int AW = $clog2(PID_COUNT);
   localparam logic [PID_W:0] PID_LIMIT = (PID_W+1)'(PID_COUNT);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(PID_COUNT - 1);

   logic             clearing_ff, clearing_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             rd_pend_ff;
   logic             rd_inrange_ff;
   logic [PID_W-1:0] cache_pid_ff;
   logic [1:0]       cache_kind_ff, cache_kind_in;
   logic             cache_started_ff, cache_started_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [2:0]       wr_data;
   logic [2:0]       rd_data;
   logic             req_inrange;
   logic [1:0]       tbl_kind;
   logic             tbl_hit;

   assign req_inrange = ({1'b0, req.pid} < PID_LIMIT);
   assign tbl_kind    = (req.kind == KIND_RSVD) ? KIND_NONE : req.kind;
   assign tbl_hit     = req.tbl_wr && req_inrange && (req.pid == cache_pid_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = req.pid[AW-1:0];
      wr_data = {cache_kind_ff, 1'b1};
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (req.set_start) begin
         wr_en = 1'b1;
      end else if (req.tbl_wr && req_inrange) begin
         wr_en   = 1'b1;
         wr_data = {tbl_kind, 1'b0};
      end
   end

   tspd_ram #(
      .WIDTH (3),
      .DEPTH (PID_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req.rd_en),
      .rd_addr (req.pid[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_in = 1'b0;
         end
      end
   end

   // a table write landing with the read data wins over it
   always_comb begin
      cache_kind_in    = cache_kind_ff;
      cache_started_in = cache_started_ff;
      if (tbl_hit) begin
         cache_kind_in    = tbl_kind;
         cache_started_in = 1'b0;
      end else if (rd_pend_ff) begin
         cache_kind_in    = rd_inrange_ff ? rd_data[2:1] : KIND_NONE;
         cache_started_in = rd_data[0];
      end else if (req.set_start) begin
         cache_started_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         rd_pend_ff  <= req.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         cache_pid_ff  <= req.pid;
         rd_inrange_ff <= req_inrange;
      end
      cache_kind_ff    <= cache_kind_in;
      cache_started_ff <= cache_started_in;
   end

   assign stat.busy    = clearing_ff;
   assign stat.kind    = cache_kind_ff;
   assign stat.started = cache_started_ff;

endmodule

### src/tspd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_parser
// packet position tracking, header extraction, adaptation field skip and
// payload selection against the cached pid table entry
// ----------------------------------------------------------------------------
module tspd_parser
   import tspd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             mode,
   input  logic [7:0]       data_byte,
   input  logic [PID_W-1:0] table_pid,
   input  logic [1:0]       table_kind,
   input  logic [7:0]       packet_length,
   input  tbl_stat_type     tbl_stat,
   output tbl_req_type      tbl_req,
   output logic             res_valid,
   output rsp_type          res_data
);

   localparam logic [7:0] PL_SIZE  = 8'(TS_PAYLOAD_SIZE);
   localparam logic [7:0] PL_LAST  = 8'(TS_PAYLOAD_SIZE - 1);
   localparam logic [7:0] AF_LIMIT = 8'(TS_PAYLOAD_SIZE - TS_HEADER_SIZE - 1);
   localparam logic [7:0] AF_BASE  = 8'(TS_HEADER_SIZE + 1);

   logic [7:0]       pos_ff, pos_in;
   logic [PID_W-1:0] pid_ff, pid_in;
   logic             us_ff, us_in;
   logic [1:0]       afc_ff, afc_in;
   logic [7:0]       poff_ff, poff_in;
   logic             skip_ff, skip_in;

   logic             stream;
   logic [7:0]       len;
   logic [8:0]       next_pos;
   logic             in_payload;
   logic             kind_ok;
   logic             first;

   assign stream   = accept && (mode == MODE_STREAM);
   assign len      = (packet_length < PL_SIZE) ? PL_SIZE : packet_length;
   assign next_pos = {1'b0, pos_ff} + 9'd1;

   assign in_payload = !skip_ff && (pos_ff != 8'd0) && (pos_ff < PL_SIZE) &&
                       (poff_ff != 8'd0) && (pos_ff >= poff_ff);
   assign kind_ok    = (tbl_stat.kind inside {KIND_VIDEO, KIND_AUDIO});
   assign first      = (pos_ff == poff_ff) && us_ff;

   always_comb begin
      pos_in  = (next_pos >= {1'b0, len}) ? 8'd0 : next_pos[7:0];
      pid_in  = pid_ff;
      us_in   = us_ff;
      afc_in  = afc_ff;
      poff_in = poff_ff;
      skip_in = skip_ff;
      tbl_req = '0;
      res_valid = 1'b0;
      res_data  = '0;
      if (accept && (mode == MODE_TABLE)) begin
         tbl_req.tbl_wr = 1'b1;
         tbl_req.pid    = table_pid;
         tbl_req.kind   = table_kind;
      end else if (stream) begin
         tbl_req.pid = pid_ff;
         if (pos_ff == 8'd0) begin
            poff_in = 8'd0;
            skip_in = (data_byte != SYNC_BYTE);
            if (data_byte != SYNC_BYTE) begin
               res_valid           = 1'b1;
               res_data.sync_error = 1'b1;
            end
         end else if (!skip_ff) begin
            if (pos_ff == 8'd1) begin
               us_in  = data_byte[6];
               pid_in = {data_byte[4:0], 8'd0};
            end else if (pos_ff == 8'd2) begin
               pid_in        = {pid_ff[PID_W-1:8], data_byte};
               tbl_req.rd_en = 1'b1;
               tbl_req.pid   = pid_in;
            end else if (pos_ff == 8'd3) begin
               afc_in  = data_byte[5:4];
               poff_in = (data_byte[5:4] == AFC_PAYLOAD_ONLY) ?
                         8'(TS_HEADER_SIZE) : 8'd0;
            end else if ((pos_ff == 8'(TS_HEADER_SIZE)) &&
                         (afc_ff == AFC_ADAPT_AND_PL)) begin
               poff_in = (data_byte < AF_LIMIT) ? (data_byte + AF_BASE) : 8'd0;
            end else if (in_payload && kind_ok) begin
               tbl_req.set_start = first;
               if (first || tbl_stat.started) begin
                  res_valid             = 1'b1;
                  res_data.payload_byte = data_byte;
                  res_data.stream_pid   = pid_ff;
                  res_data.stream_kind  = tbl_stat.kind;
                  res_data.unit_start   = first;
                  res_data.packet_end   = (pos_ff == PL_LAST);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         pid_ff  <= '0;
         us_ff   <= 1'b0;
         afc_ff  <= '0;
         poff_ff <= '0;
         skip_ff <= 1'b0;
      end else if (stream) begin
         pos_ff  <= pos_in;
         pid_ff  <= pid_in;
         us_ff   <= us_in;
         afc_ff  <= afc_in;
         poff_ff <= poff_in;
         skip_ff <= skip_in;
      end
   end

endmodule

### src/tspd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_out_buf
// output register with one skid stage so the input side keeps moving while a
// result beat waits
// ----------------------------------------------------------------------------
module tspd_out_buf
   import tspd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_stall
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

### src/transport_stream_pid_demux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transport_stream_pid_demux
// a result beat is registered in the output buffer before it appears on rsp_
// throughput: one byte or table write per cycle while req_stall is low, set
// by the single table ram port pair; req_stall rises when the output skid
// stage is full and while the pid table ram is swept to zero after reset;
// csr writes are taken throughout
// ----------------------------------------------------------------------------
module transport_stream_pid_demux
   import tspd_pkg::*;
#(
   parameter int PID_COUNT = PID_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [7:0]       req_data_byte,
   input  logic [PID_W-1:0] req_table_pid,
   input  logic [1:0]       req_table_kind,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_payload_byte,
   output logic [PID_W-1:0] rsp_stream_pid,
   output logic [1:0]       rsp_stream_kind,
   output logic             rsp_unit_start,
   output logic             rsp_packet_end,
   output logic             rsp_sync_error,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_packet_length
);

   logic [7:0]   pkt_len_ff;
   logic         accept;
   logic         full;
   tbl_req_type  tbl_req;
   tbl_stat_type tbl_stat;
   logic         res_valid;
   rsp_type      res_data;
   rsp_type      out_data;

   assign csr_ready = 1'b1;
   assign req_stall = tbl_stat.busy || full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_len_ff <= PKT_LEN_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         pkt_len_ff <= csr_packet_length;
      end
   end

   tspd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .data_byte     (req_data_byte),
      .table_pid     (req_table_pid),
      .table_kind    (req_table_kind),
      .packet_length (pkt_len_ff),
      .tbl_stat      (tbl_stat),
      .tbl_req       (tbl_req),
      .res_valid     (res_valid),
      .res_data      (res_data)
   );

   tspd_pid_table #(
      .PID_COUNT (PID_COUNT)
   ) u_pid_table (
      .clock (clock),
      .reset (reset),
      .req   (tbl_req),
      .stat  (tbl_stat)
   );

   tspd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .full      (full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_payload_byte = out_data.payload_byte;
   assign rsp_stream_pid   = out_data.stream_pid;
   assign rsp_stream_kind  = out_data.stream_kind;
   assign rsp_unit_start   = out_data.unit_start;
   assign rsp_packet_end   = out_data.packet_end;
   assign rsp_sync_error   = out_data.sync_error;

endmodule

### src/tspd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspd_checker
// port level checks of the pid demultiplexer, bound to the top level
// ----------------------------------------------------------------------------
module tspd_checker
   import tspd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [7:0]       rsp_payload_byte,
   input logic [PID_W-1:0] rsp_stream_pid,
   input logic [1:0]       rsp_stream_kind,
   input logic             rsp_unit_start,
   input logic             rsp_packet_end,
   input logic             rsp_sync_error
);

   // table sweep holds off input right after reset
   a_sweep_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input not held off during table sweep");

   a_sync_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sync_error) |->
         (rsp_payload_byte == 8'd0) && (rsp_stream_pid == '0) &&
         (rsp_stream_kind == KIND_NONE) && !rsp_unit_start && !rsp_packet_end)
      else $error("sync error beat carries payload fields");

   a_kind_passed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sync_error) |->
         ((rsp_stream_kind == KIND_VIDEO) || (rsp_stream_kind == KIND_AUDIO)))
      else $error("payload beat for an unmarked pid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_stream_pid))
      else $error("stalled result beat changed");

endmodule

bind transport_stream_pid_demux tspd_checker u_tspd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_stream_pid   (rsp_stream_pid),
   .rsp_stream_kind  (rsp_stream_kind),
   .rsp_unit_start   (rsp_unit_start),
   .rsp_packet_end   (rsp_packet_end),
   .rsp_sync_error   (rsp_sync_error)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives transport stream bytes and pid table writes into the demultiplexer
// and checks every payload beat against a cycle-free prediction of the
// packet parser. Directed packets cover unit start behind an adaptation
// field, sync loss, parity bytes at a longer packet length, a short packet
// length, table rewrites in the middle of a packet and one long output
// hold-off, with random output gaps throughout and random input gaps in all but the hold-off test.
// ----------------------------------------------------------------------------
module testbench;
   import tspd_pkg::*;

   localparam int         LONG_HOLD      = 400;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_mode = MODE_STREAM;
   logic [7:0]       req_data_byte = '0;
   logic [PID_W-1:0] req_table_pid = '0;
   logic [1:0]       req_table_kind = KIND_NONE;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_payload_byte;
   logic [PID_W-1:0] rsp_stream_pid;
   logic [1:0]       rsp_stream_kind;
   logic             rsp_unit_start;
   logic             rsp_packet_end;
   logic             rsp_sync_error;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_packet_length = PKT_LEN_DEFAULT;

   // parser state as seen from the stream
   logic [7:0]       pkt_len = PKT_LEN_DEFAULT;
   logic [7:0]       byte_pos = '0;
   logic [PID_W-1:0] hdr_pid = '0;
   logic             hdr_us = 1'b0;
   logic [1:0]       hdr_afc = '0;
   logic [7:0]       pl_off = '0;
   logic             skip_packet = 1'b0;
   logic [1:0]       kind_table [PID_COUNT_DEFAULT] = '{default: KIND_NONE};
   bit               pid_started [PID_COUNT_DEFAULT] = '{default: 1'b0};

   rsp_type          payload_beats_due [$];
   logic [PID_W-1:0] pid_pool [6];
   int               mismatch_count = 0;
   int               items_sent = 0;
   bit               quiet_sender = 1'b0;
   bit               long_hold_wanted = 1'b0;
   bit               long_hold_done = 1'b0;
   int               hold_left = 0;
   int               stall_left = 0;

   transport_stream_pid_demux dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_table_pid     (req_table_pid),
      .req_table_kind    (req_table_kind),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_stream_pid    (rsp_stream_pid),
      .rsp_stream_kind   (rsp_stream_kind),
      .rsp_unit_start    (rsp_unit_start),
      .rsp_packet_end    (rsp_packet_end),
      .rsp_sync_error    (rsp_sync_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_packet_length (csr_packet_length)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // advance the parser by one accepted item and queue the beat it yields
   task automatic demux_step(input logic mode, input logic [7:0] b,
                             input logic [PID_W-1:0] tpid, input logic [1:0] tkind);
      rsp_type    beat;
      logic [1:0] k;
      bit         first;
      int         plen;
      if (mode == MODE_TABLE) begin
         kind_table[tpid] = (tkind == KIND_RSVD) ? KIND_NONE : tkind;
         pid_started[tpid] = 1'b0;
         return;
      end
      plen = (pkt_len < TS_PAYLOAD_SIZE) ? TS_PAYLOAD_SIZE : int'(pkt_len);
      beat = '0;
      if (byte_pos == 0) begin
         pl_off = '0;
         skip_packet = (b != SYNC_BYTE);
         if (skip_packet) begin
            beat.sync_error = 1'b1;
            payload_beats_due.push_back(beat);
         end
      end else if (!skip_packet) begin
         if (byte_pos == 1) begin
            hdr_us = b[6];
            hdr_pid = {b[4:0], 8'h00};
         end else if (byte_pos == 2) begin
            hdr_pid[7:0] = b;
         end else if (byte_pos == 3) begin
            hdr_afc = b[5:4];
            pl_off = (hdr_afc == AFC_PAYLOAD_ONLY) ? 8'd4 : 8'd0;
         end else if (byte_pos == 4 && hdr_afc == AFC_ADAPT_AND_PL) begin
            pl_off = (b < TS_PAYLOAD_SIZE - 5) ? 8'(b + 8'd5) : 8'd0;
         end else if (byte_pos < TS_PAYLOAD_SIZE && pl_off != 0 && byte_pos >= pl_off) begin
            k = kind_table[hdr_pid];
            if (k == KIND_VIDEO || k == KIND_AUDIO) begin
               first = (byte_pos == pl_off) && hdr_us;
               if (first) pid_started[hdr_pid] = 1'b1;
               if (pid_started[hdr_pid]) begin
                  beat.payload_byte = b;
                  beat.stream_pid   = hdr_pid;
                  beat.stream_kind  = k;
                  beat.unit_start   = first;
                  beat.packet_end   = (byte_pos == TS_PAYLOAD_SIZE - 1);
                  payload_beats_due.push_back(beat);
               end
            end
         end
      end
      byte_pos = (int'(byte_pos) + 1 >= plen) ? 8'd0 : 8'(byte_pos + 8'd1);
   endtask

   task automatic send_ts_item(input logic mode, input logic [7:0] b,
                               input logic [PID_W-1:0] tpid, input logic [1:0] tkind);
      int gap;
      gap = pick_gap(quiet_sender);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_data_byte  <= b;
      req_table_pid  <= tpid;
      req_table_kind <= tkind;
      do @(posedge clock); while (req_stall);
      demux_step(mode, b, tpid, tkind);
      items_sent++;
   endtask

   task automatic stream_byte(input logic [7:0] b);
      send_ts_item(MODE_STREAM, b, PID_W'($urandom), 2'($urandom));
   endtask

   task automatic write_pid_kind(input logic [PID_W-1:0] pid, input logic [1:0] kind);
      send_ts_item(MODE_TABLE, 8'($urandom), pid, kind);
   endtask

   task automatic send_packet(input logic [7:0] sync, input logic [PID_W-1:0] pid,
                              input bit us, input logic [1:0] afc,
                              input logic [7:0] af_len, input bit mix_writes);
      int         total;
      logic [7:0] b;
      total = (pkt_len < TS_PAYLOAD_SIZE) ? TS_PAYLOAD_SIZE : int'(pkt_len);
      for (int i = 0; i < total; i++) begin
         case (i)
            0: b = sync;
            1: b = {1'($urandom), us, 1'($urandom), pid[12:8]};
            2: b = pid[7:0];
            3: b = {2'($urandom), afc, 4'($urandom)};
            4: b = (afc == AFC_ADAPT_AND_PL) ? af_len : 8'($urandom);
            default: b = 8'($urandom);
         endcase
         if (mix_writes && $urandom_range(0, 99) == 0)
            write_pid_kind(pid_pool[$urandom_range(0, 5)], 2'($urandom));
         stream_byte(b);
      end
   endtask

   // pad the current packet with random bytes up to the next boundary
   task automatic finish_packet();
      while (byte_pos != 0) stream_byte(8'($urandom));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (payload_beats_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_packet_length(input logic [7:0] value);
      finish_packet();
      wait_idle();
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_packet_length <= value;
      do @(posedge clock); while (!csr_ready);
      pkt_len = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // unit start on the single payload byte behind a maximal adaptation field
   task automatic test_unit_start();
      write_pid_kind(13'h1fff, KIND_VIDEO);
      write_pid_kind(13'h0000, KIND_AUDIO);
      send_packet(SYNC_BYTE, 13'h1fff, 1'b1, AFC_ADAPT_AND_PL, 8'd182, 1'b0);
   endtask

   task automatic test_sync_loss();
      send_packet(8'h00, 13'h0000, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 1'b0);
   endtask

   task automatic test_packet_length();
      set_packet_length(8'd204);
      send_packet(SYNC_BYTE, 13'h1fff, 1'b0, AFC_PAYLOAD_ONLY, 8'd0, 1'b0);
      set_packet_length(8'd0);
   endtask

   task automatic test_table_rewrite();
      pid_pool[0] = 13'h0000;
      pid_pool[1] = 13'h1fff;
      for (int i = 2; i < 6; i++) pid_pool[i] = PID_W'($urandom);
      for (int i = 0; i < 6; i++) write_pid_kind(pid_pool[i], 2'($urandom_range(1, 2)));
      send_packet(SYNC_BYTE, 13'h0000, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 1'b1);
   endtask

   task automatic test_backpressure();
      write_pid_kind(13'h0100, KIND_VIDEO);
      quiet_sender = 1'b1;
      long_hold_wanted = 1'b1;
      send_packet(SYNC_BYTE, 13'h0100, 1'b1, AFC_PAYLOAD_ONLY, 8'd0, 1'b0);
      quiet_sender = 1'b0;
   endtask

   // output side stall pattern, with one long hold-off on request
   always @(negedge clock) begin
      if (long_hold_wanted && !long_hold_done) begin
         hold_left = LONG_HOLD;
         long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(1'b0);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (payload_beats_due.size() == 0) begin
            report_mismatch($sformatf("beat with nothing due, pid %0h byte %0h",
                                      rsp_stream_pid, rsp_payload_byte));
         end else begin
            want = payload_beats_due.pop_front();
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload_byte %0h, want %0h",
                                         rsp_payload_byte, want.payload_byte));
            if (rsp_stream_pid !== want.stream_pid)
               report_mismatch($sformatf("stream_pid %0h, want %0h",
                                         rsp_stream_pid, want.stream_pid));
            if (rsp_stream_kind !== want.stream_kind)
               report_mismatch($sformatf("stream_kind %0d, want %0d",
                                         rsp_stream_kind, want.stream_kind));
            if (rsp_unit_start !== want.unit_start)
               report_mismatch($sformatf("unit_start %0b, want %0b",
                                         rsp_unit_start, want.unit_start));
            if (rsp_packet_end !== want.packet_end)
               report_mismatch($sformatf("packet_end %0b, want %0b",
                                         rsp_packet_end, want.packet_end));
            if (rsp_sync_error !== want.sync_error)
               report_mismatch($sformatf("sync_error %0b, want %0b",
                                         rsp_sync_error, want.sync_error));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_packet_length(8'd188);
      test_unit_start();
      test_sync_loss();
      test_packet_length();
      test_table_rewrite();
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // generous run limit, covering the table sweep after reset
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### transport_stream_pid_demux.f
src/tspd_pkg.sv
src/tspd_ram.sv
src/tspd_pid_table.sv
src/tspd_parser.sv
src/tspd_out_buf.sv
src/transport_stream_pid_demux.sv
src/tspd_checker.sv
sim/testbench.sv
